FILE: sv/lr4x_pkg.sv
// Shared constants and types for the LR4 crossover filter.
// No dependencies; imported by lr4x_front, lr4x_back and the top level.
`timescale 1ns / 1ps
package lr4x_pkg;

   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int COEF_WIDTH_DEF   = 32;

   // Depth of the queue between front and back, and of the result buffer
   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 2;

   typedef logic [2:0] reg_index_type;

   localparam int            NUM_REGS           = 6;
   localparam reg_index_type REG_LOW_GAIN       = 3'd0;
   localparam reg_index_type REG_HIGH_GAIN      = 3'd1;
   localparam reg_index_type REG_FEEDBACK_ONE   = 3'd2;
   localparam reg_index_type REG_FEEDBACK_TWO   = 3'd3;
   localparam reg_index_type REG_FEEDBACK_THREE = 3'd4;
   localparam reg_index_type REG_FEEDBACK_FOUR  = 3'd5;

   // Band lanes
   localparam int BAND_HIGH = 0;
   localparam int BAND_LOW  = 1;
   localparam int NUM_BANDS = 2;

   localparam int NUM_TAPS = 4;

endpackage

FILE: sv/lr4x_fifo.sv
// Small register queue with push/full and pop/empty sides.
// Depends on nothing; used between front and back and for results.
`timescale 1ns / 1ps
module lr4x_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int IW = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [IW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNTW'(do_push) - CNTW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: sv/lr4x_front.sv
// Front end: accepts samples, keeps input history, forms both numerators.
// Depends on lr4x_pkg; feeds the queue in front of lr4x_back.
`timescale 1ns / 1ps
module lr4x_front
   import lr4x_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
   localparam int NSW  = SAMPLE_WIDTH + 5,
   localparam int NUMW = NSW + 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
   input  logic                           block_end,
   input  logic signed [COEF_WIDTH-1:0]   gain [NUM_BANDS],
   input  logic                           q_pop,
   output logic                           q_push,
   output logic [2*NUMW:0]                q_data
);

   localparam int SW   = SAMPLE_WIDTH;
   localparam int CW   = COEF_WIDTH;
   localparam int PW   = CW + NSW;
   localparam int GS   = CW - 12;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (GS - 1);

   logic                  accept;
   logic [CNTW-1:0]       inflight_ff, inflight_in;
   logic signed [SW-1:0]  hist_ff [NUM_TAPS];
   logic signed [NSW-1:0] xe, h0e, h1e, h2e, h3e;
   logic signed [NSW-1:0] sum_in [NUM_BANDS];
   logic                  s1_vld_ff;
   logic signed [NSW-1:0] s1_sum_ff [NUM_BANDS];
   logic                  s1_be_ff;
   logic signed [PW-1:0]  prod [NUM_BANDS];
   logic signed [NUMW-1:0] num_in [NUM_BANDS];
   logic                  s2_vld_ff;
   logic signed [NUMW-1:0] s2_num_ff [NUM_BANDS];
   logic                  s2_be_ff;

   // credit count covers both stages and the queue, so a push always fits
   assign full        = (inflight_ff == CNTW'(QUEUE_DEPTH));
   assign accept      = push && !full;
   assign inflight_in = inflight_ff + CNTW'(accept) - CNTW'(q_pop);

   always_comb begin
      xe  = {{(NSW-SW){sample_in[SW-1]}}, sample_in};
      h0e = {{(NSW-SW){hist_ff[0][SW-1]}}, hist_ff[0]};
      h1e = {{(NSW-SW){hist_ff[1][SW-1]}}, hist_ff[1]};
      h2e = {{(NSW-SW){hist_ff[2][SW-1]}}, hist_ff[2]};
      h3e = {{(NSW-SW){hist_ff[3][SW-1]}}, hist_ff[3]};
      sum_in[BAND_LOW]  = xe + (h0e <<< 2) + (h1e <<< 2) + (h1e <<< 1)
                          + (h2e <<< 2) + h3e;
      sum_in[BAND_HIGH] = xe - (h0e <<< 2) + (h1e <<< 2) + (h1e <<< 1)
                          - (h2e <<< 2) + h3e;
   end

   always_comb begin
      for (int b = 0; b < NUM_BANDS; b++) begin
         prod[b]   = gain[b] * s1_sum_ff[b];
         prod[b]   = prod[b] + HALF;
         num_in[b] = prod[b][PW-1:GS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         for (int t = 0; t < NUM_TAPS; t++) begin
            hist_ff[t] <= '0;
         end
      end else begin
         inflight_ff <= inflight_in;
         s1_vld_ff   <= accept;
         s2_vld_ff   <= s1_vld_ff;
         if (accept) begin
            hist_ff[0] <= sample_in;
            for (int t = 1; t < NUM_TAPS; t++) begin
               hist_ff[t] <= hist_ff[t-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sum_ff <= sum_in;
         s1_be_ff  <= block_end;
      end
      if (s1_vld_ff) begin
         s2_num_ff <= num_in;
         s2_be_ff  <= s1_be_ff;
      end
   end

   assign q_push = s2_vld_ff;
   assign q_data = {s2_be_ff, s2_num_ff[BAND_HIGH], s2_num_ff[BAND_LOW]};

endmodule

FILE: sv/lr4x_back.sv
// Back end: feedback recursion of both bands, one sample per unstalled cycle.
// Depends on lr4x_pkg; reads the front queue, writes the result buffer.
`timescale 1ns / 1ps
module lr4x_back
   import lr4x_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
   localparam int NUMW = SAMPLE_WIDTH + 17,
   localparam int HW   = SAMPLE_WIDTH + 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  logic [2*NUMW:0]              q_data,
   input  logic                         o_full,
   input  logic signed [COEF_WIDTH-1:0] fb_ff [NUM_TAPS],
   input  logic signed [COEF_WIDTH-1:0] fb_in [NUM_TAPS],
   output logic                         step,
   output logic [2*HW:0]                o_data
);

   localparam int CW    = COEF_WIDTH;
   localparam int FPW   = CW + HW;
   localparam int FS    = CW - 4;
   localparam int FBW   = FPW - FS;
   localparam int PARTW = FBW + 2;
   localparam int ACCW  = NUMW + 2;
   localparam logic [FPW-1:0] FHALF = {{(FPW-1){1'b0}}, 1'b1} << (FS - 1);

   function automatic logic signed [FBW-1:0] fb_term(input logic signed [CW-1:0] c,
                                                     input logic signed [HW-1:0] h);
      logic signed [FPW-1:0] p;
      p = c * h;
      p = p + FHALF;
      return p[FPW-1:FS];
   endfunction

   function automatic logic signed [PARTW-1:0] widen(input logic signed [FBW-1:0] v);
      return {{(PARTW-FBW){v[FBW-1]}}, v};
   endfunction

   logic signed [HW-1:0]    hist_ff [NUM_BANDS][NUM_TAPS];
   logic signed [PARTW-1:0] part_ff [NUM_BANDS];
   logic signed [PARTW-1:0] part_in [NUM_BANDS];
   logic signed [NUMW-1:0]  num [NUM_BANDS];
   logic signed [FBW-1:0]   t1 [NUM_BANDS];
   logic signed [ACCW-1:0]  acc [NUM_BANDS];
   logic signed [HW-1:0]    y [NUM_BANDS];
   logic signed [HW-1:0]    ta, tb, tc;
   logic                    be;

   assign step = !q_empty && !o_full;
   assign be   = q_data[2*NUMW];
   assign num[BAND_HIGH] = q_data[2*NUMW-1:NUMW];
   assign num[BAND_LOW]  = q_data[NUMW-1:0];

   always_comb begin
      for (int b = 0; b < NUM_BANDS; b++) begin
         t1[b]  = fb_term(fb_ff[0], hist_ff[b][0]);
         acc[b] = {{(ACCW-NUMW){num[b][NUMW-1]}}, num[b]}
                  - {{(ACCW-FBW){t1[b][FBW-1]}}, t1[b]}
                  - {{(ACCW-PARTW){part_ff[b][PARTW-1]}}, part_ff[b]};
         if (!((&acc[b][ACCW-1:HW-1]) || !(|acc[b][ACCW-1:HW-1]))) begin
            y[b] = acc[b][ACCW-1] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}};
         end else begin
            y[b] = acc[b][HW-1:0];
         end
      end
   end

   // y[n-2..n-4] terms for the next sample, registered ahead of use from the
   // history as it will stand and the coefficients as they will stand
   always_comb begin
      for (int b = 0; b < NUM_BANDS; b++) begin
         if (step) begin
            ta = hist_ff[b][0];
            tb = hist_ff[b][1];
            tc = hist_ff[b][2];
         end else begin
            ta = hist_ff[b][1];
            tb = hist_ff[b][2];
            tc = hist_ff[b][3];
         end
         part_in[b] = widen(fb_term(fb_in[1], ta)) + widen(fb_term(fb_in[2], tb))
                      + widen(fb_term(fb_in[3], tc));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < NUM_BANDS; b++) begin
            part_ff[b] <= '0;
            for (int t = 0; t < NUM_TAPS; t++) begin
               hist_ff[b][t] <= '0;
            end
         end
      end else begin
         part_ff <= part_in;
         if (step) begin
            for (int b = 0; b < NUM_BANDS; b++) begin
               hist_ff[b][0] <= y[b];
               for (int t = 1; t < NUM_TAPS; t++) begin
                  hist_ff[b][t] <= hist_ff[b][t-1];
               end
            end
         end
      end
   end

   assign o_data = {be, y[BAND_HIGH], y[BAND_LOW]};

endmodule

FILE: sv/lr4_crossover_filter.sv
// Top level of the LR4 crossover: register port, front, queue, back, results.
// Depends on lr4x_pkg, lr4x_fifo, lr4x_front and lr4x_back.
`timescale 1ns / 1ps
// Fourth-order Linkwitz-Riley crossover. Each pushed sample yields one result
// holding a high band and a low band sample plus the copied block end flag.
// One sample is taken per clock cycle sustained while results are popped; a
// request passes the front stages and the queue, then the back end writes the
// result buffer. The rate is set by the back end feedback loop: per cycle one
// multiply by feedback_one, a three-term subtract and a saturation, with the
// feedback_two to feedback_four terms registered ahead of use. The front end
// holds up to four requests in flight before full rises. Coefficients are
// Q3.(COEF_WIDTH-4) at byte address 4*i (8*i above 32 bits) and should be
// written only while no request is in flight. No clearing pass after reset.
module lr4_crossover_filter
   import lr4x_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = COEF_WIDTH_DEF,
   localparam int DW = (COEF_WIDTH > 32) ? 64 : 32,
   localparam int AW = (COEF_WIDTH > 32) ? 6 : 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   input  logic                           req_block_end,
   output logic                           empty,
   input  logic                           pop,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_high_band,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_low_band,
   output logic                           rsp_block_end_out,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [AW-1:0]                  paddr,
   input  logic [DW-1:0]                  pwdata,
   output logic [DW-1:0]                  prdata,
   output logic                           pready
);

   localparam int SW   = SAMPLE_WIDTH;
   localparam int CW   = COEF_WIDTH;
   localparam int HW   = SW + 8;
   localparam int NUMW = SW + 17;
   localparam int QW   = 2 * NUMW + 1;
   localparam int OW   = 2 * HW + 1;

   function automatic logic signed [SW-1:0] to_sample(input logic signed [HW-1:0] v);
      logic [HW:0] t;
      logic [SW:0] s;
      t = {v[HW-1], v} + (HW+1)'(128);
      s = t[HW:8];
      if (s[SW] != s[SW-1]) begin
         return s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end
      return s[SW-1:0];
   endfunction

   logic signed [CW-1:0] coef_ff [NUM_REGS];
   logic signed [CW-1:0] coef_in [NUM_REGS];
   logic                 wr;
   reg_index_type        idx;
   logic signed [CW-1:0] gain [NUM_BANDS];
   logic signed [CW-1:0] fb_ff [NUM_TAPS];
   logic signed [CW-1:0] fb_in [NUM_TAPS];
   logic signed [CW-1:0] rd_val;

   logic                 q_push, q_full, q_empty, step;
   logic [QW-1:0]        q_wr_data, q_rd_data;
   logic                 o_full;
   logic [OW-1:0]        o_wr_data, o_rd_data;

   // register port
   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign idx    = paddr[AW-1:AW-3];

   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         coef_in[i] = (wr && idx == reg_index_type'(i)) ? pwdata[CW-1:0] : coef_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         coef_ff <= coef_in;
      end
   end

   always_comb begin
      rd_val = (idx < reg_index_type'(NUM_REGS)) ? coef_ff[idx] : '0;
      prdata = {{(DW-CW){rd_val[CW-1]}}, rd_val};
   end

   always_comb begin
      gain[BAND_LOW]  = coef_ff[REG_LOW_GAIN];
      gain[BAND_HIGH] = coef_ff[REG_HIGH_GAIN];
      fb_ff[0] = coef_ff[REG_FEEDBACK_ONE];
      fb_ff[1] = coef_ff[REG_FEEDBACK_TWO];
      fb_ff[2] = coef_ff[REG_FEEDBACK_THREE];
      fb_ff[3] = coef_ff[REG_FEEDBACK_FOUR];
      fb_in[0] = coef_in[REG_FEEDBACK_ONE];
      fb_in[1] = coef_in[REG_FEEDBACK_TWO];
      fb_in[2] = coef_in[REG_FEEDBACK_THREE];
      fb_in[3] = coef_in[REG_FEEDBACK_FOUR];
   end

   lr4x_front #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .sample_in(req_sample_in),
      .block_end(req_block_end),
      .gain     (gain),
      .q_pop    (step),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   lr4x_fifo #(
      .WIDTH(QW),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_data(q_wr_data),
      .full   (q_full),
      .pop    (step),
      .rd_data(q_rd_data),
      .empty  (q_empty)
   );

   lr4x_back #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_empty(q_empty),
      .q_data (q_rd_data),
      .o_full (o_full),
      .fb_ff  (fb_ff),
      .fb_in  (fb_in),
      .step   (step),
      .o_data (o_wr_data)
   );

   lr4x_fifo #(
      .WIDTH(OW),
      .DEPTH(OUT_DEPTH)
   ) u_results (
      .clock  (clock),
      .reset  (reset),
      .push   (step),
      .wr_data(o_wr_data),
      .full   (o_full),
      .pop    (pop),
      .rd_data(o_rd_data),
      .empty  (empty)
   );

   // round off the extra fraction bits on the way out
   assign rsp_block_end_out = o_rd_data[2*HW];
   assign rsp_high_band     = to_sample(o_rd_data[2*HW-1:HW]);
   assign rsp_low_band      = to_sample(o_rd_data[HW-1:0]);

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("front pushed a request into a full queue");

   a_back_waits_for_room: assert property (@(posedge clock) disable iff (reset)
      step |-> (!o_full && !q_empty))
      else $error("back stepped without a request or without result room");

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> empty)
      else $error("result side not empty after reset");

   a_no_result_without_request: assert property (@(posedge clock) disable iff (reset)
      ($past(reset) && !$past(push)) |-> !step)
      else $error("back stepped on a request that was never taken");

endmodule

FILE: tb/lr4_crossover_filter_test.sv
// Self-checking testbench for the LR4 crossover filter: predicts both bands per request
// and checks every result. Depends on lr4x_pkg and the lr4_crossover_filter top level.
`timescale 1ns / 1ps
module lr4_crossover_filter_test;
   import lr4x_pkg::*;

   localparam int SW = SAMPLE_WIDTH_DEF;
   localparam int CW = COEF_WIDTH_DEF;
   localparam int HW = SW + 8;
   localparam int GAIN_SHIFT = CW - 12;
   localparam int FEEDBACK_SHIFT = CW - 4;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef logic signed [SW-1:0] sample_type;
   typedef logic signed [HW-1:0] hist_type;
   typedef logic signed [CW-1:0] coef_type;

   typedef struct {
      sample_type high;
      sample_type low;
      logic       block_end;
   } band_result_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam coef_type COEF_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam coef_type COEF_MIN = {1'b1, {(CW-1){1'b0}}};

   localparam reg_index_type FIRST_UNUSED_REG = reg_index_type'(NUM_REGS);
   localparam reg_index_type LAST_UNUSED_REG  = reg_index_type'(NUM_REGS + 1);

   // 1 kHz crossover at 48 kHz, Q3.28
   localparam coef_type XO_LOW_GAIN  = 32'sd4115;
   localparam coef_type XO_HIGH_GAIN = 32'sd223069864;
   localparam coef_type XO_FB_ONE    = -32'sd974603242;
   localparam coef_type XO_FB_TWO    = 32'sd1330763404;
   localparam coef_type XO_FB_THREE  = -32'sd809901983;
   localparam coef_type XO_FB_FOUR   = 32'sd185376158;
   localparam coef_type UNITY        = 32'sd268435456;

   logic            clock;
   logic            reset;
   logic            push;
   logic            full;
   sample_type      req_sample_in;
   logic            req_block_end;
   logic            empty;
   logic            pop;
   sample_type      rsp_high_band;
   sample_type      rsp_low_band;
   logic            rsp_block_end_out;
   logic            psel;
   logic            penable;
   logic            pwrite;
   logic [4:0]      paddr;
   logic [31:0]     pwdata;
   logic [31:0]     prdata;
   logic            pready;

   lr4_crossover_filter u_top (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_sample_in     (req_sample_in),
      .req_block_end     (req_block_end),
      .empty             (empty),
      .pop               (pop),
      .rsp_high_band     (rsp_high_band),
      .rsp_low_band      (rsp_low_band),
      .rsp_block_end_out (rsp_block_end_out),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // predictor state
   coef_type   coef_regs [NUM_REGS];
   sample_type input_taps [4];
   hist_type   high_taps [4];
   hist_type   low_taps [4];
   band_result_type expected_bands [$];

   int mismatches = 0;
   int burst_left = 0;
   bit sender_gaps = 1'b1;
   bit receiver_stalls = 1'b1;
   int hold_request = 0;
   int walk_level = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------- prediction ----------------
   function automatic logic signed [127:0] round_product(logic signed [127:0] a,
                                                         logic signed [127:0] b, int shift);
      logic signed [127:0] p;
      p = a * b;
      return (p + (128'sd1 <<< (shift - 1))) >>> shift;
   endfunction

   function automatic logic signed [127:0] clamp(logic signed [127:0] v, int w);
      logic signed [127:0] hi, lo;
      hi = (128'sd1 <<< (w - 1)) - 128'sd1;
      lo = -(128'sd1 <<< (w - 1));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic hist_type band_state(coef_type gain, int numsum,
                                           hist_type h0, hist_type h1,
                                           hist_type h2, hist_type h3);
      logic signed [127:0] acc;
      acc = round_product(gain, numsum, GAIN_SHIFT);
      acc = acc - round_product(coef_regs[REG_FEEDBACK_ONE], h0, FEEDBACK_SHIFT);
      acc = acc - round_product(coef_regs[REG_FEEDBACK_TWO], h1, FEEDBACK_SHIFT);
      acc = acc - round_product(coef_regs[REG_FEEDBACK_THREE], h2, FEEDBACK_SHIFT);
      acc = acc - round_product(coef_regs[REG_FEEDBACK_FOUR], h3, FEEDBACK_SHIFT);
      acc = clamp(acc, HW);
      return acc[HW-1:0];
   endfunction

   function automatic sample_type band_sample(hist_type y);
      logic signed [127:0] t;
      t = y;
      t = clamp((t + 128'sd128) >>> 8, SW);
      return t[SW-1:0];
   endfunction

   task automatic predict_crossover(sample_type s, logic be);
      int lsum, hsum;
      hist_type yh, yl;
      band_result_type r;
      lsum = int'(s) + 4 * int'(input_taps[0]) + 6 * int'(input_taps[1])
             + 4 * int'(input_taps[2]) + int'(input_taps[3]);
      hsum = int'(s) - 4 * int'(input_taps[0]) + 6 * int'(input_taps[1])
             - 4 * int'(input_taps[2]) + int'(input_taps[3]);
      yh = band_state(coef_regs[REG_HIGH_GAIN], hsum,
                      high_taps[0], high_taps[1], high_taps[2], high_taps[3]);
      yl = band_state(coef_regs[REG_LOW_GAIN], lsum,
                      low_taps[0], low_taps[1], low_taps[2], low_taps[3]);
      for (int k = 3; k > 0; k--) begin
         high_taps[k] = high_taps[k-1];
         low_taps[k] = low_taps[k-1];
         input_taps[k] = input_taps[k-1];
      end
      high_taps[0] = yh;
      low_taps[0] = yl;
      input_taps[0] = s;
      r.high = band_sample(yh);
      r.low = band_sample(yl);
      r.block_end = be;
      expected_bands.push_back(r);
   endtask

   // ---------------- checking ----------------
   task automatic note_mismatch(string field, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %0s: expected %0d, got %0d", field, want, got);
   endtask

   always @(posedge clock) begin : result_check
      band_result_type e;
      if (!reset && pop && !empty) begin
         if (expected_bands.size() == 0) begin
            note_mismatch("unexpected result, high band", 0, rsp_high_band);
         end else begin
            e = expected_bands.pop_front();
            if (rsp_high_band !== e.high) note_mismatch("high_band", e.high, rsp_high_band);
            if (rsp_low_band !== e.low) note_mismatch("low_band", e.low, rsp_low_band);
            if (rsp_block_end_out !== e.block_end)
               note_mismatch("block_end_out", e.block_end, rsp_block_end_out);
         end
      end
   end

   // receiver: random stall pattern, plus a long hold-off on request
   initial begin : receiver
      int hold_left, pattern_age, pattern_pos, pattern_len;
      logic [31:0] stall_pattern;
      hold_left = 0;
      pattern_age = 0;
      pattern_pos = 0;
      pattern_len = 1;
      stall_pattern = '1;
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else if (!receiver_stalls) begin
            pop <= 1'b1;
         end else begin
            if (pattern_age == 0) begin
               stall_pattern = $urandom;
               pattern_len = $urandom_range(3, 32);
               pattern_age = $urandom_range(20, 200);
               pattern_pos = 0;
            end
            pattern_age--;
            pop <= stall_pattern[pattern_pos];
            pattern_pos = (pattern_pos + 1) % pattern_len;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (push && !full) || (pop && !empty) || (psel && penable && pready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   // ---------------- drivers ----------------
   task automatic send_sample(sample_type s, logic be);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_gaps ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      push <= 1'b1;
      req_sample_in <= s;
      req_block_end <= be;
      do @(posedge clock); while (full);
      predict_crossover(s, be);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      push <= 1'b0;
      while (expected_bands.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx < NUM_REGS) coef_regs[idx] = value;
   endtask

   task automatic csr_check(reg_index_type idx);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== coef_regs[idx]) note_mismatch("register readback", coef_regs[idx], prdata);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic load_coefficients(coef_type lg, coef_type hg, coef_type f1, coef_type f2,
                                    coef_type f3, coef_type f4);
      csr_write(REG_LOW_GAIN, lg);
      csr_write(REG_HIGH_GAIN, hg);
      csr_write(REG_FEEDBACK_ONE, f1);
      csr_write(REG_FEEDBACK_TWO, f2);
      csr_write(REG_FEEDBACK_THREE, f3);
      csr_write(REG_FEEDBACK_FOUR, f4);
   endtask

   task automatic load_crossover();
      load_coefficients(XO_LOW_GAIN, XO_HIGH_GAIN, XO_FB_ONE, XO_FB_TWO, XO_FB_THREE,
                        XO_FB_FOUR);
   endtask

   // mix of full-range noise, extremes and a slow random walk
   function automatic sample_type pick_sample();
      int step;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return sample_type'($urandom);
         4: begin
            case ($urandom_range(0, 4))
               0: return SAMPLE_MAX;
               1: return SAMPLE_MIN;
               2: return sample_type'(0);
               3: return sample_type'(-1);
               default: return sample_type'(1);
            endcase
         end
         default: begin
            step = int'($urandom_range(0, 131072)) - 65536;
            walk_level = walk_level + step;
            if (walk_level > int'(SAMPLE_MAX)) walk_level = int'(SAMPLE_MAX);
            if (walk_level < int'(SAMPLE_MIN)) walk_level = int'(SAMPLE_MIN);
            return sample_type'(walk_level);
         end
      endcase
   endfunction

   task automatic send_random(int n);
      repeat (n) send_sample(pick_sample(), ($urandom_range(0, 15) == 0));
   endtask

   // ---------------- tests ----------------
   task automatic test_register_access();
      for (int i = 0; i < NUM_REGS; i++) csr_check(reg_index_type'(i));
      for (int i = 0; i < NUM_REGS; i++) csr_write(reg_index_type'(i), $urandom);
      // writes past the last register must leave the others alone
      csr_write(FIRST_UNUSED_REG, $urandom);
      csr_write(LAST_UNUSED_REG, $urandom);
      for (int i = 0; i < NUM_REGS; i++) csr_check(reg_index_type'(i));
   endtask

   task automatic test_zero_coefficients();
      load_coefficients(0, 0, 0, 0, 0, 0);
      send_random(10);
      wait_until_drained();
   endtask

   task automatic test_directed_extremes();
      load_crossover();
      repeat (4) send_sample(SAMPLE_MAX, 1'b0);
      repeat (4) send_sample(SAMPLE_MIN, 1'b0);
      send_sample(sample_type'(0), 1'b1);
      send_sample(sample_type'(-1), 1'b0);
      send_sample(sample_type'(1), 1'b1);
      for (int i = 0; i < 6; i++) send_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX, (i == 5));
      wait_until_drained();
      // full-scale gain with no feedback: history and output both saturate
      load_coefficients(COEF_MAX, COEF_MAX, 0, 0, 0, 0);
      repeat (3) send_sample(SAMPLE_MAX, 1'b0);
      repeat (3) send_sample(SAMPLE_MIN, 1'b1);
      wait_until_drained();
   endtask

   task automatic test_crossover_stream();
      load_crossover();
      send_random(650);
      wait_until_drained();
   endtask

   task automatic test_overdriven_crossover();
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      load_coefficients(UNITY, COEF_MAX, XO_FB_ONE, XO_FB_TWO, XO_FB_THREE, XO_FB_FOUR);
      send_random(300);
      wait_until_drained();
      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   task automatic test_random_coefficients();
      repeat (4) begin
         load_coefficients($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         send_random(100);
         wait_until_drained();
      end
   endtask

   task automatic test_coefficient_extremes();
      load_coefficients(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      send_random(40);
      wait_until_drained();
      load_coefficients(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      send_random(40);
      wait_until_drained();
      load_coefficients(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      send_random(40);
      wait_until_drained();
      load_coefficients(COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      send_random(40);
      wait_until_drained();
   endtask

   task automatic test_backpressure();
      load_crossover();
      sender_gaps = 1'b0;
      hold_request = HOLD_OFF_CYCLES;
      send_random(150);
      sender_gaps = 1'b1;
      send_random(50);
      wait_until_drained();
   endtask

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_sample_in = '0;
      req_block_end = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      for (int k = 0; k < NUM_REGS; k++) coef_regs[k] = '0;
      for (int k = 0; k < 4; k++) begin
         input_taps[k] = '0;
         high_taps[k] = '0;
         low_taps[k] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_access();
      test_zero_coefficients();
      test_directed_extremes();
      test_crossover_stream();
      test_overdriven_crossover();
      test_random_coefficients();
      test_coefficient_extremes();
      test_backpressure();

      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: files.f
sv/lr4x_pkg.sv
sv/lr4x_fifo.sv
sv/lr4x_front.sv
sv/lr4x_back.sv
sv/lr4_crossover_filter.sv
tb/lr4_crossover_filter_test.sv
